/* rtl/tbcd_pkg.sv */
// shared widths, codes and types of the two-button chord keypad decoder
package tbcd_pkg;

    localparam int BTN_W   = 3;
    localparam int EV_W    = 3;
    localparam int WIN_W   = 16;
    localparam int ALERT_W = 4;
    localparam int STATE_W = 4;
    localparam int TAP_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_EV  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_COUNT = 1'd1;

    localparam logic [WIN_W-1:0]   TAP_WINDOW_RST  = 16'd200;
    localparam logic [ALERT_W-1:0] ALERT_COUNT_RST = 4'd3;

    localparam logic [BTN_W-1:0] BTN_A    = 3'd0;
    localparam logic [BTN_W-1:0] BTN_B    = 3'd1;
    localparam logic [BTN_W-1:0] BTN_D    = 3'd2;
    localparam logic [BTN_W-1:0] BTN_UP   = 3'd3;
    localparam logic [BTN_W-1:0] BTN_DOWN = 3'd4;

    localparam logic [EV_W-1:0] EV_ALERT  = 3'd0;
    localparam logic [EV_W-1:0] EV_RESET  = 3'd1;
    localparam logic [EV_W-1:0] EV_SELECT = 3'd2;
    localparam logic [EV_W-1:0] EV_VALUE  = 3'd3;
    localparam logic [EV_W-1:0] EV_UPDATE = 3'd4;
    localparam logic [EV_W-1:0] EV_INCR   = 3'd5;

    localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STATE_W-1:0] ST_A_SEL = 4'd1;
    localparam logic [STATE_W-1:0] ST_A_VAL = 4'd2;
    localparam logic [STATE_W-1:0] ST_A_UPD = 4'd3;
    localparam logic [STATE_W-1:0] ST_A_INC = 4'd4;
    localparam logic [STATE_W-1:0] ST_B_SEL = 4'd5;
    localparam logic [STATE_W-1:0] ST_B_VAL = 4'd6;
    localparam logic [STATE_W-1:0] ST_B_UPD = 4'd7;
    localparam logic [STATE_W-1:0] ST_B_INC = 4'd8;

    // tap owner ids
    localparam logic [1:0] TAP_NONE = 2'd0;
    localparam logic [1:0] TAP_A    = 2'd1;
    localparam logic [1:0] TAP_B    = 2'd2;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic [EV_W-1:0]  code;
    } ev_t;

endpackage

/* rtl/two_button_chord_keypad_decoder.sv */
// top level of the two-button chord keypad decoder
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, a/b/d/up/down_level           | item in
//  out     | out_valid, out_stall, button, event_code, last    | item out
//  cfg     | cfg_we, cfg_index, cfg_data                        | write only
//
// a tick is taken into an input register, decoded there once the result buffer frees up,
// and its zero to three events loaded into a three-entry result buffer
// events leave one per cycle while out_stall is low, so a tick with events holds
// the input until its last event leaves; ticks with no event pass at one per cycle
// rst_n clears the chord state, tap tracking, edge history and both buffers
// out_stall holds the buffer head; unsent events then stall the input register

module two_button_chord_keypad_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           a_level,
    input  logic                           b_level,
    input  logic                           d_level,
    input  logic                           up_level,
    input  logic                           down_level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tbcd_pkg::BTN_W-1:0]     button,
    output logic [tbcd_pkg::EV_W-1:0]      event_code,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbcd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbcd_pkg::*;

    // configuration
    logic [WIN_W-1:0]   win_reg;
    logic [ALERT_W-1:0] alert_cnt_reg;

    // input register
    logic       in_vld_reg;
    logic       a_reg, b_reg, d_reg, up_reg, down_reg;
    logic       in_vld_next;
    logic       in_acc;

    // decoder state
    logic [STATE_W-1:0] state_reg, state_next;
    logic [TAP_W-1:0]   tap_cnt_reg, tap_cnt_next;
    logic [1:0]         tap_btn_reg, tap_btn_next;
    logic [WIN_W-1:0]   ticks_reg, ticks_next;
    logic [1:0]         prev_ud_reg;
    logic               prev_d_reg;

    // result buffer
    ev_t        buf_reg [MAX_EV];
    ev_t        buf_next [MAX_EV];
    ev_t        buf_new [MAX_EV];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] n_ev;

    logic       proc;
    logic       pop;

    // decode signals
    logic [1:0]       ud, ab;
    logic [WIN_W-1:0] tst;
    logic [TAP_W-1:0] tap_inc;
    logic [BTN_W-1:0] chord_btn;
    logic [1:0]       chord_id;
    logic             recent;
    logic             ud_ev, d_ev, ch_ev;
    logic [BTN_W-1:0] ud_btn;
    ev_t              ch_item;

    assign pop       = out_valid && !out_stall;
    assign proc      = in_vld_reg && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop));
    assign in_stall  = in_vld_reg && !proc;
    assign in_acc    = in_valid && !in_stall;
    assign in_vld_next = in_acc ? 1'b1 : (proc ? 1'b0 : in_vld_reg);

    assign out_valid  = (cnt_reg != 2'd0);
    assign button     = buf_reg[0].button;
    assign event_code = buf_reg[0].code;
    assign last       = (cnt_reg == 2'd1);

    assign ud  = {down_reg, up_reg};
    assign ab  = {b_reg, a_reg};
    assign tst = (ticks_reg != {WIN_W{1'b1}}) ? ticks_reg + 1'b1 : ticks_reg;
    assign tap_inc = (tap_cnt_reg != {TAP_W{1'b1}}) ? tap_cnt_reg + 1'b1 : tap_cnt_reg;

    assign chord_btn = (state_reg inside {[ST_B_SEL:ST_B_INC]}) ? BTN_B : BTN_A;
    assign chord_id  = (chord_btn == BTN_A) ? TAP_A : TAP_B;
    assign recent    = (tap_btn_reg == chord_id) && (tst < win_reg);

    // up/down only from both released; pressing both together gives nothing
    assign ud_ev  = (prev_ud_reg == 2'b00) && (ud == 2'b01 || ud == 2'b10);
    assign ud_btn = ud[0] ? BTN_UP : BTN_DOWN;
    assign d_ev   = !prev_d_reg && d_reg;

    always_comb
    begin
        state_next   = state_reg;
        tap_cnt_next = tap_cnt_reg;
        tap_btn_next = tap_btn_reg;
        ticks_next   = tst;
        ch_ev        = 1'b0;
        ch_item      = '{button: chord_btn, code: EV_VALUE};
        case (state_reg)
            ST_A_SEL, ST_B_SEL:
            begin
                if (ab == 2'b00)
                begin
                    state_next = ST_IDLE;
                    if (recent)
                    begin
                        if (tap_inc >= alert_cnt_reg)
                        begin
                            ch_ev        = 1'b1;
                            ch_item.code = EV_ALERT;
                            tap_cnt_next = '0;
                            tap_btn_next = TAP_NONE;
                            ticks_next   = '0;
                        end
                        else
                        begin
                            tap_cnt_next = tap_inc;
                        end
                    end
                    else
                    begin
                        ch_ev        = 1'b1;
                        ch_item.code = EV_RESET;
                        tap_cnt_next = {{(TAP_W-1){1'b0}}, 1'b1};
                        tap_btn_next = chord_id;
                        ticks_next   = '0;
                    end
                end
                else if (ab == 2'b11)
                begin
                    state_next = (chord_btn == BTN_A) ? ST_A_VAL : ST_B_VAL;
                    ch_ev      = 1'b1;
                end
            end
            ST_A_VAL:
            begin
                if (ab == 2'b01)
                begin
                    state_next   = ST_A_INC;
                    ch_ev        = 1'b1;
                    ch_item.code = EV_INCR;
                end
                else if (ab == 2'b10)
                begin
                    state_next   = ST_A_UPD;
                    ch_ev        = 1'b1;
                    ch_item.code = EV_UPDATE;
                end
            end
            ST_B_VAL:
            begin
                if (ab == 2'b01)
                begin
                    state_next   = ST_B_UPD;
                    ch_ev        = 1'b1;
                    ch_item.code = EV_UPDATE;
                end
                else if (ab == 2'b10)
                begin
                    state_next   = ST_B_INC;
                    ch_ev        = 1'b1;
                    ch_item.code = EV_INCR;
                end
            end
            ST_A_UPD, ST_A_INC, ST_B_UPD, ST_B_INC:
            begin
                if (ab == 2'b00)
                begin
                    state_next   = ST_IDLE;
                    ch_ev        = 1'b1;
                    ch_item.code = EV_RESET;
                end
                else if (ab == 2'b11)
                begin
                    state_next = (chord_btn == BTN_A) ? ST_A_VAL : ST_B_VAL;
                    ch_ev      = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                if (ab == 2'b01 || ab == 2'b10)
                begin
                    state_next     = (ab == 2'b01) ? ST_A_SEL : ST_B_SEL;
                    ch_item.button = (ab == 2'b01) ? BTN_A : BTN_B;
                    ch_item.code   = EV_SELECT;
                    // a quick re-press of the same button is a tap, not a select
                    ch_ev          = (tap_btn_reg != ab) || (tst >= win_reg);
                end
            end
        endcase
    end

    // pack the tick's events in order: up/down, d, chord
    always_comb
    begin
        n_ev = 2'd0;
        for (int i = 0; i < MAX_EV; i++)
        begin
            buf_new[i] = '{button: BTN_A, code: EV_ALERT};
        end
        if (ud_ev)
        begin
            buf_new[n_ev] = '{button: ud_btn, code: EV_UPDATE};
            n_ev = n_ev + 2'd1;
        end
        if (d_ev)
        begin
            buf_new[n_ev] = '{button: BTN_D, code: EV_UPDATE};
            n_ev = n_ev + 2'd1;
        end
        if (ch_ev)
        begin
            buf_new[n_ev] = ch_item;
            n_ev = n_ev + 2'd1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_EV; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (proc)
        begin
            cnt_next = n_ev;
            for (int i = 0; i < MAX_EV; i++)
            begin
                buf_next[i] = buf_new[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < MAX_EV - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= TAP_WINDOW_RST;
            alert_cnt_reg <= ALERT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_WINDOW:  win_reg       <= cfg_data[WIN_W-1:0];
                CFG_ALERT_COUNT: alert_cnt_reg <= cfg_data[ALERT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            state_reg   <= ST_IDLE;
            tap_cnt_reg <= '0;
            tap_btn_reg <= TAP_NONE;
            ticks_reg   <= '0;
            prev_ud_reg <= 2'b00;
            prev_d_reg  <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            if (proc)
            begin
                state_reg   <= state_next;
                tap_cnt_reg <= tap_cnt_next;
                tap_btn_reg <= tap_btn_next;
                ticks_reg   <= ticks_next;
                prev_ud_reg <= ud;
                prev_d_reg  <= d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_reg    <= a_level;
            b_reg    <= b_level;
            d_reg    <= d_level;
            up_reg   <= up_level;
            down_reg <= down_level;
        end
        for (int i = 0; i < MAX_EV; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3 || !in_vld_reg || !proc || pop)
        else $error("buffer reload while events remain");

    a_proc_free: assert property (@(posedge clk) disable iff (!rst_n)
        proc |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("tick decoded into a busy buffer");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= ST_B_INC)
        else $error("chord state out of range");

    a_tap_owner: assert property (@(posedge clk) disable iff (!rst_n)
        tap_btn_reg != 2'd3 && (tap_btn_reg != TAP_NONE || tap_cnt_reg == '0))
        else $error("tap tracking inconsistent");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the two-button chord keypad decoder: directed table, random phases
module testbench;
    import tbcd_pkg::*;

    // key bits of one tick: a, b, d, up, down
    localparam logic [4:0] KEY_NONE = 5'b00000;
    localparam logic [4:0] KEY_A    = 5'b00001;
    localparam logic [4:0] KEY_B    = 5'b00010;
    localparam logic [4:0] KEY_D    = 5'b00100;
    localparam logic [4:0] KEY_UP   = 5'b01000;
    localparam logic [4:0] KEY_DN   = 5'b10000;

    localparam logic [1:0] AB_NONE = 2'd0;
    localparam logic [1:0] AB_A    = 2'd1;
    localparam logic [1:0] AB_B    = 2'd2;
    localparam logic [1:0] AB_BOTH = 2'd3;
    localparam logic [1:0] UD_UP   = 2'd1;
    localparam logic [1:0] UD_DOWN = 2'd2;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_TICKS   = 50;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic [EV_W-1:0]  code;
        logic             last;
    } key_result_t;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [4:0]            keys;
        logic                  typed;
        logic [1:0]            count;
        ev_t [2:0]             ev;
    } stim_row_t;

    localparam ev_t NO_EV = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  a_level;
    logic                  b_level;
    logic                  d_level;
    logic                  up_level;
    logic                  down_level;
    logic                  out_valid;
    logic                  out_stall;
    logic [BTN_W-1:0]      button;
    logic [EV_W-1:0]       event_code;
    logic                  last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    two_button_chord_keypad_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_level    (a_level),
        .b_level    (b_level),
        .d_level    (d_level),
        .up_level   (up_level),
        .down_level (down_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .button     (button),
        .event_code (event_code),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // decoder state as predicted
    logic [STATE_W-1:0] chord;
    logic [TAP_W-1:0]   tap_cnt;
    logic [1:0]         tap_owner;
    logic [WIN_W-1:0]   since_tap;
    logic [1:0]         prev_ud;
    logic               prev_d;
    logic [WIN_W-1:0]   window;
    logic [ALERT_W-1:0] alert_cnt;

    key_result_t tick_events[$];
    key_result_t pending_events[$];
    stim_row_t   directed_rows[$];
    stim_row_t   cur_row;
    logic [4:0]  noise_keys;

    logic tick_taken;
    logic hold_off_req;
    logic quiet;
    int   fails;
    int   ticks_sent;
    int   events_checked;
    int   reg_writes;
    int   ev_seen[0:7];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function void add_event(input logic [BTN_W-1:0] btn, input logic [EV_W-1:0] code);
        tick_events.push_back({btn, code, 1'b0});
    endfunction

    function void decode_tick(input logic [4:0] keys);
        logic [1:0]       ab;
        logic [1:0]       ud;
        logic [1:0]       id;
        logic [BTN_W-1:0] src;
        key_result_t      tail;
        tick_events.delete();
        ab  = keys[1:0];
        ud  = keys[4:3];
        src = (chord >= ST_B_SEL && chord <= ST_B_INC) ? BTN_B : BTN_A;
        if (since_tap != 16'hFFFF)
            since_tap = since_tap + 1'b1;
        if (prev_ud == AB_NONE)
        begin
            if (ud == UD_UP)
                add_event(BTN_UP, EV_UPDATE);
            else if (ud == UD_DOWN)
                add_event(BTN_DOWN, EV_UPDATE);
        end
        prev_ud = ud;
        if (!prev_d && keys[2])
            add_event(BTN_D, EV_UPDATE);
        prev_d = keys[2];
        case (chord)
            ST_A_SEL, ST_B_SEL:
            begin
                id = (src == BTN_A) ? TAP_A : TAP_B;
                if (ab == AB_NONE)
                begin
                    chord = ST_IDLE;
                    if (tap_owner == id && since_tap < window)
                    begin
                        if (tap_cnt != 4'd15)
                            tap_cnt = tap_cnt + 1'b1;
                        if (tap_cnt >= alert_cnt)
                        begin
                            add_event(src, EV_ALERT);
                            tap_cnt   = '0;
                            tap_owner = TAP_NONE;
                            since_tap = '0;
                        end
                    end
                    else
                    begin
                        tap_cnt   = 4'd1;
                        tap_owner = id;
                        since_tap = '0;
                        add_event(src, EV_RESET);
                    end
                end
                else if (ab == AB_BOTH)
                begin
                    chord = (src == BTN_A) ? ST_A_VAL : ST_B_VAL;
                    add_event(src, EV_VALUE);
                end
            end
            ST_A_VAL:
            begin
                if (ab == AB_A)
                begin
                    chord = ST_A_INC;
                    add_event(BTN_A, EV_INCR);
                end
                else if (ab == AB_B)
                begin
                    chord = ST_A_UPD;
                    add_event(BTN_A, EV_UPDATE);
                end
            end
            ST_B_VAL:
            begin
                if (ab == AB_A)
                begin
                    chord = ST_B_UPD;
                    add_event(BTN_B, EV_UPDATE);
                end
                else if (ab == AB_B)
                begin
                    chord = ST_B_INC;
                    add_event(BTN_B, EV_INCR);
                end
            end
            ST_A_UPD, ST_A_INC, ST_B_UPD, ST_B_INC:
            begin
                if (ab == AB_NONE)
                begin
                    chord = ST_IDLE;
                    add_event(src, EV_RESET);
                end
                else if (ab == AB_BOTH)
                begin
                    chord = (src == BTN_A) ? ST_A_VAL : ST_B_VAL;
                    add_event(src, EV_VALUE);
                end
            end
            default:
            begin
                chord = ST_IDLE;
                if (ab == AB_A || ab == AB_B)
                begin
                    id    = (ab == AB_A) ? TAP_A : TAP_B;
                    chord = (ab == AB_A) ? ST_A_SEL : ST_B_SEL;
                    // a quick re-press of the tapping button stays silent
                    if (tap_owner != id || since_tap >= window)
                        add_event((ab == AB_A) ? BTN_A : BTN_B, EV_SELECT);
                end
            end
        endcase
        if (tick_events.size() > 0)
        begin
            tail = tick_events.pop_back();
            tail.last = 1'b1;
            tick_events.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        key_result_t want;
        int i;
        if (!rst_n)
            tick_taken = 1'b0;
        else
        begin
            tick_taken = in_valid && !in_stall;
            if (tick_taken)
            begin
                decode_tick({down_level, up_level, d_level, b_level, a_level});
                if (cur_row.typed)
                begin
                    for (i = 0; i < cur_row.count; i++)
                        pending_events.push_back({cur_row.ev[i].button, cur_row.ev[i].code,
                                                  i == cur_row.count - 1});
                end
                else
                begin
                    foreach (tick_events[i])
                        pending_events.push_back(tick_events[i]);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected item: button %0d event_code %0d last %0d",
                           button, event_code, last);
                    fails++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    events_checked++;
                    ev_seen[event_code]++;
                    if (button !== want.button)
                    begin
                        $error("button: expected %0d, got %0d", want.button, button);
                        fails++;
                    end
                    if (event_code !== want.code)
                    begin
                        $error("event_code: expected %0d, got %0d", want.code, event_code);
                        fails++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fails++;
                    end
                end
            end
        end
    end

    // output side: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 12)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    task add_row(input logic [4:0] keys, input logic typed, input logic [1:0] count,
                 input ev_t e0, input ev_t e1, input ev_t e2);
        stim_row_t r;
        r       = '0;
        r.keys  = keys;
        r.typed = typed;
        r.count = count;
        r.ev[0] = e0;
        r.ev[1] = e1;
        r.ev[2] = e2;
        directed_rows.push_back(r);
    endtask

    task add_tick(input logic [4:0] keys);
        add_row(keys, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV);
    endtask

    task add_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.index    = index;
        r.data     = data;
        directed_rows.push_back(r);
    endtask

    // called at a falling edge; returns at a falling edge once the item is taken and any gap ends
    task drive_row(input stim_row_t r);
        cur_row    = r;
        in_valid   <= 1'b1;
        a_level    <= r.keys[0];
        b_level    <= r.keys[1];
        d_level    <= r.keys[2];
        up_level   <= r.keys[3];
        down_level <= r.keys[4];
        do
            @(negedge clk);
        while (!tick_taken);
        ticks_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task put_tick(input logic a, input logic b);
        stim_row_t r;
        int k;
        for (k = 2; k < 5; k++)
            if ($urandom_range(0, 3) == 0)
                noise_keys[k] = ~noise_keys[k];
        r      = '0;
        r.keys = {noise_keys[4:2], b, a};
        drive_row(r);
    endtask

    task wait_drain();
        int cycles;
        in_valid <= 1'b0;
        cycles = 0;
        while (pending_events.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            cycles++;
        end
        if (pending_events.size() != 0)
        begin
            $error("%0d expected items never arrived", pending_events.size());
            fails++;
            pending_events.delete();
        end
        // ticks with no events may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_TAP_WINDOW)
            window = data;
        else
            alert_cnt = data[ALERT_W-1:0];
        reg_writes++;
        @(negedge clk);
    endtask

    task run_random(input int count);
        int   stop_at;
        int   kind;
        int   reps;
        int   gap;
        int   i;
        logic pick;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at)
        begin
            kind = $urandom_range(0, 19);
            pick = 1'($urandom_range(0, 1));
            if (kind < 8)
            begin
                // tap bursts of one button, some gaps long enough to leave the window
                reps = $urandom_range(1, alert_cnt + 2);
                for (i = 0; i < reps; i++)
                begin
                    repeat ($urandom_range(1, 2)) put_tick(!pick, pick);
                    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 45)
                                                      : $urandom_range(1, 2);
                    repeat (gap) put_tick(1'b0, 1'b0);
                end
            end
            else if (kind < 15)
            begin
                // chord: select, then value and single-button moves, then release
                repeat ($urandom_range(1, 2)) put_tick(!pick, pick);
                reps = $urandom_range(1, 3);
                for (i = 0; i < reps; i++)
                begin
                    repeat ($urandom_range(1, 2)) put_tick(1'b1, 1'b1);
                    pick = 1'($urandom_range(0, 1));
                    repeat ($urandom_range(1, 2)) put_tick(!pick, pick);
                end
                put_tick(1'b0, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    put_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task run_phase(input logic [WIN_W-1:0] win, input logic [ALERT_W-1:0] cnt);
        wait_drain();
        write_reg(CFG_TAP_WINDOW, win);
        // upper data bits are junk for the 4-bit register
        write_reg(CFG_ALERT_COUNT, {12'($urandom_range(0, 4095)), cnt});
        run_random(PHASE_TICKS);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        a_level      = 1'b0;
        b_level      = 1'b0;
        d_level      = 1'b0;
        up_level     = 1'b0;
        down_level   = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        quiet        = 1'b0;
        noise_keys   = '0;
        cur_row      = '0;
        fails          = 0;
        ticks_sent     = 0;
        events_checked = 0;
        reg_writes     = 0;
        foreach (ev_seen[i])
            ev_seen[i] = 0;
        chord     = ST_IDLE;
        tap_cnt   = '0;
        tap_owner = TAP_NONE;
        since_tap = '0;
        prev_ud   = '0;
        prev_d    = 1'b0;
        window    = TAP_WINDOW_RST;
        alert_cnt = ALERT_COUNT_RST;

        // reset values in force: up/down rules, both chord paths, a run of taps
        add_row(KEY_NONE, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV);
        add_row(KEY_UP | KEY_A | KEY_B, 1'b1, 2'd1, {BTN_UP, EV_UPDATE}, NO_EV, NO_EV);
        add_row(KEY_UP | KEY_DN, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV);
        add_row(KEY_NONE, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV);
        add_row(KEY_UP | KEY_DN, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV);
        add_row(KEY_NONE, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV);
        add_row(KEY_DN | KEY_D | KEY_A, 1'b1, 2'd3,
                {BTN_DOWN, EV_UPDATE}, {BTN_D, EV_UPDATE}, {BTN_A, EV_SELECT});
        add_row(KEY_A | KEY_B, 1'b1, 2'd1, {BTN_A, EV_VALUE}, NO_EV, NO_EV);
        add_row(KEY_B, 1'b1, 2'd1, {BTN_A, EV_UPDATE}, NO_EV, NO_EV);
        add_row(KEY_A | KEY_B, 1'b1, 2'd1, {BTN_A, EV_VALUE}, NO_EV, NO_EV);
        add_row(KEY_A, 1'b1, 2'd1, {BTN_A, EV_INCR}, NO_EV, NO_EV);
        add_row(KEY_NONE, 1'b1, 2'd1, {BTN_A, EV_RESET}, NO_EV, NO_EV);
        add_row(KEY_B, 1'b1, 2'd1, {BTN_B, EV_SELECT}, NO_EV, NO_EV);
        add_row(KEY_A | KEY_B, 1'b1, 2'd1, {BTN_B, EV_VALUE}, NO_EV, NO_EV);
        add_row(KEY_A, 1'b1, 2'd1, {BTN_B, EV_UPDATE}, NO_EV, NO_EV);
        add_row(KEY_A | KEY_B, 1'b1, 2'd1, {BTN_B, EV_VALUE}, NO_EV, NO_EV);
        add_row(KEY_B, 1'b1, 2'd1, {BTN_B, EV_INCR}, NO_EV, NO_EV);
        add_row(KEY_NONE, 1'b1, 2'd1, {BTN_B, EV_RESET}, NO_EV, NO_EV);
        add_tick(KEY_A);
        add_tick(KEY_NONE);
        add_tick(KEY_A);
        add_tick(KEY_NONE);
        add_tick(KEY_A);
        add_tick(KEY_NONE);
        // zero window: no tap counts; then widest window with alert below two
        add_write(CFG_TAP_WINDOW, 16'd0);
        add_write(CFG_ALERT_COUNT, 16'd1);
        add_tick(KEY_A);
        add_tick(KEY_NONE);
        add_tick(KEY_A);
        add_tick(KEY_NONE);
        add_write(CFG_TAP_WINDOW, 16'hFFFF);
        add_tick(KEY_A);
        add_tick(KEY_NONE);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                wait_drain();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                drive_row(directed_rows[i]);
        end

        run_phase(16'd1, 4'd2);
        run_phase(16'hFFFF, 4'd15);
        run_phase(16'($urandom_range(4, 40)), 4'($urandom_range(2, 5)));
        wait_drain();
        write_reg(CFG_TAP_WINDOW, 16'($urandom_range(4, 40)));
        write_reg(CFG_ALERT_COUNT, {12'd0, 4'($urandom_range(2, 15))});
        // receiver holds off while the sender keeps offering ticks
        hold_off_req = 1'b1;
        run_random(PHASE_TICKS);
        run_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(2, 15)));
        quiet = 1'b1;
        run_phase(16'($urandom_range(4, 40)), 4'($urandom_range(2, 4)));
        wait_drain();

        $display("testbench: %0d ticks, %0d events checked, %0d register writes,",
                 ticks_sent, events_checked, reg_writes);
        $display("testbench: one long output hold; alert %0d reset %0d select %0d",
                 ev_seen[EV_ALERT], ev_seen[EV_RESET], ev_seen[EV_SELECT]);
        $display("testbench: value %0d update %0d incr %0d",
                 ev_seen[EV_VALUE], ev_seen[EV_UPDATE], ev_seen[EV_INCR]);
        if (fails == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
